/* hw/rtl/kmnp_pkg.sv */
// Shared types and constants for the keypad matrix new-press scanner.
package kmnp_pkg;

    localparam int ROW_FIELD_W   = 5;
    localparam int COL_W         = 4;
    localparam int ROW_CODE_W    = 3;
    localparam int CODE_W        = ROW_CODE_W + COL_W;
    localparam int MAX_COLUMNS   = 16;
    localparam int DEF_COLUMNS   = 16;
    localparam int DEF_ROWS      = 5;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 8;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FORGET = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [ROW_FIELD_W-1:0] row_levels;
    } item_t;

    typedef struct packed {
        logic              key_found;
        logic [CODE_W-1:0] key_code;
    } result_t;

endpackage

/* hw/rtl/kmnp_in_stage.sv */
// Input register stage that holds one accepted item until the scan logic takes it.
module kmnp_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kmnp_pkg::item_t in_item,
    input  logic            advance,
    output logic            valid,
    output kmnp_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    kmnp_pkg::item_t item_reg;
    logic            accept;

    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

/* hw/rtl/kmnp_detect.sv */
// Column tracking, previous-state store and new-press detection for one scan.
module kmnp_detect
#(
    parameter int COLUMNS = kmnp_pkg::DEF_COLUMNS,
    parameter int ROWS    = kmnp_pkg::DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  kmnp_pkg::item_t   item,
    output logic              last_col,
    output kmnp_pkg::result_t result
);

    localparam int RW = kmnp_pkg::ROW_FIELD_W;
    localparam int CW = kmnp_pkg::COL_W;
    localparam int KW = kmnp_pkg::CODE_W;
    localparam int RCW = kmnp_pkg::ROW_CODE_W;
    localparam logic [RW-1:0] ROW_MASK =
        (ROWS >= RW) ? {RW{1'b1}} : RW'((32'd1 << ROWS) - 32'd1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    logic [RW-1:0] prev_reg [kmnp_pkg::MAX_COLUMNS];
    logic [RW-1:0] prev_next [kmnp_pkg::MAX_COLUMNS];
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [KW-1:0] best_reg;
    logic [KW-1:0] best_next;
    logic          found_reg;
    logic          found_next;

    logic [RW-1:0]  now_rows;
    logic [RW-1:0]  fresh;
    logic           hit;
    logic [RCW-1:0] hit_row;
    logic [KW-1:0]  scan_best;
    logic           scan_found;

    assign last_col = (col_reg == LAST_COL);
    assign now_rows = ~item.row_levels & ROW_MASK;
    assign fresh    = now_rows & ~prev_reg[col_reg];

    // The highest new row in this column wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_row = '0;
        for (int r = 0; r < RW; r++)
        begin
            if (fresh[r])
            begin
                hit     = 1'b1;
                hit_row = RCW'(r);
            end
        end
    end

    assign scan_best       = hit ? {hit_row, col_reg} : best_reg;
    assign scan_found      = found_reg || hit;
    assign result.key_found = scan_found;
    assign result.key_code  = scan_found ? scan_best : '0;

    always_comb
    begin
        prev_next  = prev_reg;
        col_next   = col_reg;
        best_next  = best_reg;
        found_next = found_reg;
        if (step)
        begin
            if (item.func == kmnp_pkg::FUNC_FORGET)
            begin
                for (int c = 0; c < kmnp_pkg::MAX_COLUMNS; c++)
                begin
                    prev_next[c] = '0;
                end
            end
            else
            begin
                prev_next[col_reg] = now_rows;
                if (last_col)
                begin
                    col_next   = '0;
                    best_next  = '0;
                    found_next = 1'b0;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    best_next  = scan_best;
                    found_next = scan_found;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < kmnp_pkg::MAX_COLUMNS; c++)
            begin
                prev_reg[c] <= '0;
            end
            col_reg   <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            col_reg   <= col_next;
            best_reg  <= best_next;
            found_reg <= found_next;
        end
    end

endmodule

/* hw/rtl/kmnp_out_stage.sv */
// Output register that holds one scan result until it is taken.
module kmnp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  kmnp_pkg::result_t load_result,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output kmnp_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    kmnp_pkg::result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

/* hw/rtl/keypad_matrix_new_press_scanner.sv */
// Top level of the keypad matrix new-press scanner.
//
// Channel   Direction  Item
// s_axis    in         one column sample (tdata) or a forget-history command (tuser)
// m_axis    out        one scan result after the final column: key code and found flag
//
// One item is accepted every cycle unless a final-column sample is held back by a result waiting
// on m_axis_tready; m_axis_tvalid rises as that sample moves from the input to the output register.
// Reset clears the previous-press store, the column counter and the valid flags of both registers.
// While a result waits on m_axis_tready, one further item is held in the input
// register; sample and forget items that produce no result still pass freely.
module keypad_matrix_new_press_scanner
#(
    parameter int COLUMNS = kmnp_pkg::DEF_COLUMNS,
    parameter int ROWS    = kmnp_pkg::DEF_ROWS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: row_levels[4:0], zero fill.
    input  logic [kmnp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: func.
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: key_code[6:0], zero fill.
    output logic [kmnp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: key_found.
    output logic                                 m_axis_tuser
);

    kmnp_pkg::item_t   in_item;
    kmnp_pkg::item_t   held_item;
    kmnp_pkg::result_t scan_result;
    kmnp_pkg::result_t out_result;
    logic              held_valid;
    logic              advance;
    logic              last_col;
    logic              produces;
    logic              out_free;

    assign in_item.func       = s_axis_tuser;
    assign in_item.row_levels = s_axis_tdata[kmnp_pkg::ROW_FIELD_W-1:0];

    assign produces = (held_item.func == kmnp_pkg::FUNC_SAMPLE) && last_col;
    assign advance  = held_valid && (!produces || out_free);

    kmnp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .advance  (advance),
        .valid    (held_valid),
        .item     (held_item)
    );

    kmnp_detect
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_detect
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (held_item),
        .last_col (last_col),
        .result   (scan_result)
    );

    kmnp_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && produces),
        .load_result (scan_result),
        .free        (out_free),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = kmnp_pkg::OUT_TDATA_W'(out_result.key_code);
    assign m_axis_tuser = out_result.key_found;

endmodule

/* verif/testbench.sv */
// Testbench for the keypad matrix new-press scanner with random and directed scans.
`timescale 1ns / 1ps

module testbench;

    localparam int   ROW_FIELD_W = kmnp_pkg::ROW_FIELD_W;
    localparam int   COL_W       = kmnp_pkg::COL_W;
    localparam int   ROW_CODE_W  = kmnp_pkg::ROW_CODE_W;
    localparam int   CODE_W      = kmnp_pkg::CODE_W;
    localparam int   MAX_COLUMNS = kmnp_pkg::MAX_COLUMNS;
    localparam int   DEF_COLUMNS = kmnp_pkg::DEF_COLUMNS;
    localparam int   DEF_ROWS    = kmnp_pkg::DEF_ROWS;
    localparam int   IN_TDATA_W  = kmnp_pkg::IN_TDATA_W;
    localparam int   OUT_TDATA_W = kmnp_pkg::OUT_TDATA_W;
    localparam logic FUNC_SAMPLE = kmnp_pkg::FUNC_SAMPLE;
    localparam logic FUNC_FORGET = kmnp_pkg::FUNC_FORGET;
    typedef kmnp_pkg::result_t result_t;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_ITEMS = 35;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT_SCAN = 8;
    localparam int SETTLE       = 16;
    localparam logic [ROW_FIELD_W-1:0] ROW_MASK     = ROW_FIELD_W'((1 << DEF_ROWS) - 1);
    localparam logic [ROW_FIELD_W-1:0] ALL_RELEASED = '1;
    localparam logic [ROW_FIELD_W-1:0] ALL_PRESSED  = '0;

    // Tracks the pressed rows of every column and queues the result of each finished scan.
    class new_press_scoreboard;
        logic [ROW_FIELD_W-1:0] held_rows [MAX_COLUMNS];
        logic [COL_W-1:0]       column;
        logic [CODE_W-1:0]      best_code;
        logic                   found;
        result_t                expected_scans [$];
        int                     errors;

        function new();
            foreach (held_rows[i])
                held_rows[i] = '0;
            column    = '0;
            best_code = '0;
            found     = 1'b0;
            errors    = 0;
        endfunction

        function void take_item(logic func, logic [ROW_FIELD_W-1:0] raw);
            logic [ROW_FIELD_W-1:0] pressed;
            logic [ROW_FIELD_W-1:0] fresh;
            result_t                scan_result;
            int                     row;
            if (func == FUNC_FORGET)
            begin
                foreach (held_rows[i])
                    held_rows[i] = '0;
                return;
            end
            pressed = ~raw & ROW_MASK;
            fresh   = pressed & ~held_rows[column];
            for (row = ROW_FIELD_W - 1; row >= 0; row--)
            begin
                if (fresh[row])
                begin
                    best_code = {ROW_CODE_W'(row), column};
                    found     = 1'b1;
                    break;
                end
            end
            held_rows[column] = pressed;
            if (column == DEF_COLUMNS - 1)
            begin
                scan_result.key_found = found;
                scan_result.key_code  = found ? best_code : '0;
                expected_scans.push_back(scan_result);
                column    = '0;
                best_code = '0;
                found     = 1'b0;
            end
            else
            begin
                column = column + 1'b1;
            end
        endfunction

        function void check_scan(logic key_found, logic [CODE_W-1:0] key_code);
            result_t want;
            if (expected_scans.size() == 0)
            begin
                $error("unexpected result: key_found %0d, key_code %0d", key_found, key_code);
                errors++;
                return;
            end
            want = expected_scans.pop_front();
            if (key_found !== want.key_found)
            begin
                $error("key_found: expected %0d, actual %0d", want.key_found, key_found);
                errors++;
            end
            if (key_code !== want.key_code)
            begin
                $error("key_code: expected %0d, actual %0d", want.key_code, key_code);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    new_press_scoreboard    scans;
    logic [ROW_FIELD_W-1:0] last_raw [MAX_COLUMNS];
    bit                     tx_steady;
    int                     items_sent;
    int                     cycle_count = 0;

    keypad_matrix_new_press_scanner i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            scans.check_scan(m_axis_tuser, m_axis_tdata[CODE_W-1:0]);
    end

    task automatic send_item(input logic func, input logic [ROW_FIELD_W-1:0] raw);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= IN_TDATA_W'(raw);
        do
            @(posedge clk);
        while (!s_axis_tready);
        scans.take_item(func, raw);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (scans.expected_scans.size() != 0);
    endtask

    // The receiver stalls at random, with one long hold-off while the sender keeps going.
    initial
    begin
        int wait_cycles;
        int results_seen;
        bit held_long;
        bit rx_steady;
        results_seen = 0;
        held_long    = 1'b0;
        rx_steady    = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen == HOLD_AT_SCAN && !held_long)
            begin
                held_long = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (results_seen % 16 == 0)
                    rx_steady = ($urandom_range(0, 2) == 0);
                wait_cycles = rx_steady ? 0 : $urandom_range(0, 11);
                if (wait_cycles > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            results_seen++;
        end
    end

    initial
    begin
        int                     col;
        int                     scan_no;
        logic [ROW_FIELD_W-1:0] raw;
        scans       = new();
        items_sent  = 0;
        tx_steady   = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_SAMPLE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Forgetting at rest, then a lone press at row 0 of column 0, which gives code 0.
        send_item(FUNC_FORGET, ALL_PRESSED);
        send_item(FUNC_FORGET, ALL_RELEASED);
        for (col = 0; col < DEF_COLUMNS; col++)
            send_item(FUNC_SAMPLE, (col == 0) ? 5'h1e : ALL_RELEASED);
        // Every key down with a forget in mid-scan; the top corner wins.
        for (col = 0; col < DEF_COLUMNS; col++)
        begin
            if (col == DEF_COLUMNS / 2)
                send_item(FUNC_FORGET, 5'h15);
            send_item(FUNC_SAMPLE, ALL_PRESSED);
        end
        drain_results();
        foreach (last_raw[i])
            last_raw[i] = ALL_PRESSED;

        scan_no = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (scan_no > 20 && $urandom_range(0, 9) == 0)
                drain_results();
            for (col = 0; col < DEF_COLUMNS; col++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_item(FUNC_FORGET, ROW_FIELD_W'($urandom_range(0, 31)));
                case ($urandom_range(0, 3))
                    0: raw = ALL_RELEASED;
                    1: raw = last_raw[col];
                    2: raw = ROW_FIELD_W'($urandom_range(0, 31));
                    default: raw = last_raw[col] & ~(ROW_FIELD_W'(1) << $urandom_range(0, 4));
                endcase
                last_raw[col] = raw;
                send_item(FUNC_SAMPLE, raw);
            end
            scan_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (scans.expected_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (scans.errors == 0 && scans.expected_scans.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/kmnp_pkg.sv
hw/rtl/kmnp_in_stage.sv
hw/rtl/kmnp_detect.sv
hw/rtl/kmnp_out_stage.sv
hw/rtl/keypad_matrix_new_press_scanner.sv
verif/testbench.sv
